FILE: design/duration_string_to_ms_core_defines.svh
// ----------------------------------------------------------------------------
// Duration string to milliseconds: assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DURATION_STRING_TO_MS_CORE_DEFINES_SVH
`define DURATION_STRING_TO_MS_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSTM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSTM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/dstm_pkg.sv
// ----------------------------------------------------------------------------
// dstm_pkg
// Shared status codes, unit codes, unit scale constants and the record that
// travels from the scanner to the scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package dstm_pkg;

	// Result status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_DIGIT = 3'd1;
	localparam logic [2:0] ST_RANGE    = 3'd2;
	localparam logic [2:0] ST_NEGATIVE = 3'd3;
	localparam logic [2:0] ST_SUFFIX   = 3'd4;
	localparam logic [2:0] ST_MS_OVF   = 3'd5;

	// Unit codes.
	localparam logic [2:0] UNIT_MS  = 3'd0;
	localparam logic [2:0] UNIT_SEC = 3'd1;
	localparam logic [2:0] UNIT_MIN = 3'd2;
	localparam logic [2:0] UNIT_HR  = 3'd3;
	localparam logic [2:0] UNIT_DAY = 3'd4;

	localparam int MILLIS_W = 63;
	localparam int SCALE_W  = 27;

	localparam longint unsigned SEC_PER_DAY = 60 * 60 * 24;
	localparam longint unsigned MS_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;

	localparam longint unsigned SCALE_SEC = 1000;
	localparam longint unsigned SCALE_MIN = 60 * 1000;
	localparam longint unsigned SCALE_HR  = 60 * 60 * 1000;
	localparam longint unsigned SCALE_DAY = SEC_PER_DAY * 1000;

	localparam longint unsigned LIMIT_SEC = MS_MAX / SCALE_SEC;
	localparam longint unsigned LIMIT_MIN = MS_MAX / SCALE_MIN;
	localparam longint unsigned LIMIT_HR  = MS_MAX / SCALE_HR;
	localparam longint unsigned LIMIT_DAY = MS_MAX / SCALE_DAY;

	typedef struct packed {
		logic [2:0]          status;
		logic [2:0]          unit;
		logic [MILLIS_W-1:0] mag;
	} dstm_fin_t;

	function automatic logic [SCALE_W-1:0] unit_scale(input logic [2:0] unit);
		logic [SCALE_W-1:0] r;
		case (unit)
			UNIT_MS:  r = SCALE_W'(1);
			UNIT_SEC: r = SCALE_W'(SCALE_SEC);
			UNIT_MIN: r = SCALE_W'(SCALE_MIN);
			UNIT_HR:  r = SCALE_W'(SCALE_HR);
			UNIT_DAY: r = SCALE_W'(SCALE_DAY);
			default:  r = SCALE_W'(1);
		endcase
		return r;
	endfunction

	// Largest magnitude that still scales to at most MS_MAX.
	function automatic logic [MILLIS_W-1:0] unit_limit(input logic [2:0] unit);
		logic [MILLIS_W-1:0] r;
		case (unit)
			UNIT_MS:  r = MILLIS_W'(MS_MAX);
			UNIT_SEC: r = MILLIS_W'(LIMIT_SEC);
			UNIT_MIN: r = MILLIS_W'(LIMIT_MIN);
			UNIT_HR:  r = MILLIS_W'(LIMIT_HR);
			UNIT_DAY: r = MILLIS_W'(LIMIT_DAY);
			default:  r = MILLIS_W'(MS_MAX);
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/dstm_scan.sv
// ----------------------------------------------------------------------------
// dstm_scan
// Byte scanner: whitespace, sign, decimal accumulation and suffix tracking.
// The last byte of a string loads the finished record into stage 1.
// ----------------------------------------------------------------------------
`default_nettype none

module dstm_scan (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire logic [7:0]        character,
	input  wire logic              char_valid,
	input  wire logic              last,
	output logic                   fin_valid,
	input  wire logic              fin_ready,
	output dstm_pkg::dstm_fin_t    fin
);
	import dstm_pkg::*;

	localparam logic [2:0] PH_SPACE  = 3'd0;
	localparam logic [2:0] PH_SIGN   = 3'd1;
	localparam logic [2:0] PH_DIGITS = 3'd2;
	localparam logic [2:0] PH_SUFFIX = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	localparam logic [2:0] SUF_EMPTY = 3'd0;
	localparam logic [2:0] SUF_S     = 3'd1;
	localparam logic [2:0] SUF_M     = 3'd2;
	localparam logic [2:0] SUF_MS    = 3'd3;
	localparam logic [2:0] SUF_H     = 3'd4;
	localparam logic [2:0] SUF_D     = 3'd5;
	localparam logic [2:0] SUF_BAD   = 3'd6;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_S     = 8'h73;

	localparam logic [67:0] MAG_LIMIT = {4'b0, 1'b1, 63'b0};

	logic [2:0]  phase_q, n_phase;
	logic        neg_q, n_neg;
	logic [63:0] mag_q, n_mag;
	logic        seen_q, n_seen;
	logic        rerr_q, n_rerr;
	logic [2:0]  suf_q, n_suf;

	logic        valid_s1;
	dstm_fin_t   fin_s1;
	dstm_fin_t   n_fin;

	logic        is_digit, is_space, take_digit, accept;
	logic [3:0]  dval;
	logic [67:0] mac;

	function automatic logic [2:0] suffix_next(input logic [2:0] s, input logic [7:0] c);
		logic [2:0] r;
		case (s)
			SUF_EMPTY: begin
				if (c == CH_S)      r = SUF_S;
				else if (c == CH_M) r = SUF_M;
				else if (c == CH_H) r = SUF_H;
				else if (c == CH_D) r = SUF_D;
				else                r = SUF_BAD;
			end
			SUF_M:   r = (c == CH_S) ? SUF_MS : SUF_BAD;
			default: r = SUF_BAD;
		endcase
		return r;
	endfunction

	assign accept     = item_valid && item_ready;
	assign item_ready = !valid_s1 || fin_ready;
	assign fin_valid  = valid_s1;
	assign fin        = fin_s1;

	assign is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
	assign is_space = (character == CH_SPACE) || ((character >= CH_TAB) && (character <= CH_CR));
	assign dval     = character[3:0];
	assign mac      = {1'b0, mag_q, 3'b0} + {3'b0, mag_q, 1'b0} + {64'b0, dval};

	always_comb begin
		n_phase    = phase_q;
		n_neg      = neg_q;
		n_mag      = mag_q;
		n_seen     = seen_q;
		n_rerr     = rerr_q;
		n_suf      = suf_q;
		take_digit = 1'b0;
		if (char_valid) begin
			case (phase_q)
				PH_SPACE: begin
					if (is_space) begin
						n_phase = PH_SPACE;
					end else if (character == CH_PLUS || character == CH_MINUS) begin
						n_neg   = (character == CH_MINUS);
						n_phase = PH_SIGN;
					end else if (is_digit) begin
						take_digit = 1'b1;
						n_phase    = PH_DIGITS;
					end else begin
						n_phase = PH_DONE;
					end
				end
				PH_SIGN: begin
					if (is_digit) begin
						take_digit = 1'b1;
						n_phase    = PH_DIGITS;
					end else begin
						n_phase = PH_DONE;
					end
				end
				PH_DIGITS, PH_SUFFIX: begin
					if (character == CH_NUL) begin
						n_phase = PH_DONE;
					end else if (is_digit && phase_q == PH_DIGITS) begin
						take_digit = 1'b1;
					end else begin
						n_suf   = suffix_next(suf_q, character);
						n_phase = PH_SUFFIX;
					end
				end
				default: begin
					n_phase = phase_q;
				end
			endcase
		end
		if (take_digit) begin
			n_seen = 1'b1;
			if (!rerr_q) begin
				if (mac > MAG_LIMIT) n_rerr = 1'b1;
				else                 n_mag  = mac[63:0];
			end
		end
	end

	// Status before scaling, and the unit the magnitude is scaled by.
	always_comb begin
		n_fin.mag = n_mag[MILLIS_W-1:0];
		case (n_suf)
			SUF_EMPTY, SUF_S: n_fin.unit = UNIT_SEC;
			SUF_MS:           n_fin.unit = UNIT_MS;
			SUF_M:            n_fin.unit = UNIT_MIN;
			SUF_H:            n_fin.unit = UNIT_HR;
			SUF_D:            n_fin.unit = UNIT_DAY;
			default:          n_fin.unit = UNIT_MS;
		endcase
		if (!n_seen)
			n_fin.status = ST_NO_DIGIT;
		else if (n_rerr || (!n_neg && n_mag[63]))
			n_fin.status = ST_RANGE;
		else if (n_neg && (n_mag != 64'd0))
			n_fin.status = ST_NEGATIVE;
		else if (n_suf == SUF_BAD)
			n_fin.status = ST_SUFFIX;
		else
			n_fin.status = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			mag_q   <= 64'd0;
			seen_q  <= 1'b0;
			rerr_q  <= 1'b0;
			suf_q   <= SUF_EMPTY;
		end else if (accept) begin
			if (last) begin
				phase_q <= PH_SPACE;
				neg_q   <= 1'b0;
				mag_q   <= 64'd0;
				seen_q  <= 1'b0;
				rerr_q  <= 1'b0;
				suf_q   <= SUF_EMPTY;
			end else begin
				phase_q <= n_phase;
				neg_q   <= n_neg;
				mag_q   <= n_mag;
				seen_q  <= n_seen;
				rerr_q  <= n_rerr;
				suf_q   <= n_suf;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && last) begin
			valid_s1 <= 1'b1;
		end else if (fin_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			fin_s1 <= n_fin;
		end
	end

endmodule

`default_nettype wire

FILE: design/dstm_scale.sv
// ----------------------------------------------------------------------------
// dstm_scale
// Scales the magnitude to milliseconds with two registered partial products
// and checks it against the per-unit limit; drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dstm_scale (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fin_valid,
	output logic                               fin_ready,
	input  wire dstm_pkg::dstm_fin_t           fin,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic [dstm_pkg::MILLIS_W-1:0]      millis,
	output logic [2:0]                         status
);
	import dstm_pkg::*;

	localparam int LO_W = 32;
	localparam int HI_W = MILLIS_W - LO_W;

	logic                      valid_s2, valid_s3;
	logic [2:0]                status_s2, status_s3;
	logic                      ovf_s2;
	logic [LO_W+SCALE_W-1:0]   plo_s2;
	logic [HI_W+SCALE_W-1:0]   phi_s2;
	logic [MILLIS_W-1:0]       millis_s3;

	logic [SCALE_W-1:0]        scale;
	logic                      s2_ready, load_s2, load_s3;
	logic [MILLIS_W-1:0]       sum;

	assign scale     = unit_scale(fin.unit);
	assign s2_ready  = !valid_s3 || result_ready;
	assign fin_ready = !valid_s2 || s2_ready;
	assign load_s2   = fin_valid && fin_ready;
	assign load_s3   = valid_s2 && s2_ready;

	assign sum = {phi_s2[HI_W-1:0], {LO_W{1'b0}}}
		+ {{(MILLIS_W-LO_W-SCALE_W){1'b0}}, plo_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (load_s2)       valid_s2 <= 1'b1;
			else if (s2_ready) valid_s2 <= 1'b0;
			if (load_s3)           valid_s3 <= 1'b1;
			else if (result_ready) valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			status_s2 <= fin.status;
			ovf_s2    <= (fin.mag > unit_limit(fin.unit));
			plo_s2    <= fin.mag[LO_W-1:0] * scale;
			phi_s2    <= fin.mag[MILLIS_W-1:LO_W] * scale;
		end
		if (load_s3) begin
			if (status_s2 != ST_OK) begin
				status_s3 <= status_s2;
				millis_s3 <= '0;
			end else if (ovf_s2) begin
				status_s3 <= ST_MS_OVF;
				millis_s3 <= '0;
			end else begin
				status_s3 <= ST_OK;
				millis_s3 <= sum;
			end
		end
	end

	assign result_valid = valid_s3;
	assign millis       = millis_s3;
	assign status       = status_s3;

endmodule

`default_nettype wire

FILE: design/duration_string_to_ms_core.sv
// ----------------------------------------------------------------------------
// duration_string_to_ms_core
// Parses a duration string, one byte per beat, into milliseconds and a status.
// ----------------------------------------------------------------------------
// Usage:
// The item channel (item_valid/item_ready) carries one byte of the string per
// beat in character, with char_valid marking a real byte and last marking the
// final beat of the string. A beat with char_valid low and last high closes an
// empty string; a beat with both low is a no-op. Each string yields exactly one
// beat on the result channel (result_valid/result_ready): millis and status.
// Throughput is one byte per cycle while item_ready is high; bytes of the
// next string may follow the last byte of the previous one directly. The
// scanner state advances on every accepted beat, and the final beat loads a
// three-stage result pipeline (scan record, registered partial products,
// result register) that the result passes through before result_valid rises.
// When the receiver stalls, results back up through the three stages; item_ready
// drops only once the scan record stage is occupied and cannot move on.
// Reset clears the scanner to the leading whitespace state and empties the
// pipeline; no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "duration_string_to_ms_core_defines.svh"

module duration_string_to_ms_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire logic [7:0]                    character,
	input  wire logic                          char_valid,
	input  wire logic                          last,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic [dstm_pkg::MILLIS_W-1:0]      millis,
	output logic [2:0]                         status
);
	import dstm_pkg::*;

	// Finished scan record between the scanner and the scaler.
	logic      fin_valid;
	logic      fin_ready;
	dstm_fin_t fin;

	dstm_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.character  (character),
		.char_valid (char_valid),
		.last       (last),
		.fin_valid  (fin_valid),
		.fin_ready  (fin_ready),
		.fin        (fin)
	);

	dstm_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.fin_valid    (fin_valid),
		.fin_ready    (fin_ready),
		.fin          (fin),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.millis       (millis),
		.status       (status)
	);

	// Any error status must come with a zero value.
	`DSTM_ASSERT_NOW(a_err_zero, result_valid && (status != ST_OK), millis == '0, "error result with nonzero millis")

	// The final beat of a string must land in the scan record stage.
	`DSTM_ASSERT_NEXT(a_last_loads, item_valid && item_ready && last, fin_valid, "last beat did not load a result")

	// Input back-pressure only comes from a blocked scan record stage.
	`DSTM_ASSERT_NOW(a_ready_cause, !item_ready, fin_valid && !fin_ready, "item_ready low without a blocked record")

endmodule

`default_nettype wire
